FILE: rtl/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
`default_nettype none

package sdf_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int VALUE_W         = 32;
	localparam int COUNT_FIELD_W   = 7;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic                      keep;
		logic [COUNT_FIELD_W-1:0]  unique_count;
		logic                      end_of_array;
		logic                      overflow;
	} out_word_t;

	// Word traveling down the cell chain with its search status
	typedef struct packed {
		logic                      vld;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic                      hit;
		logic                      placed;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/sdf_cell.sv
// One store cell: holds one distinct value and checks each passing word against it.
`default_nettype none

module sdf_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire sdf_pkg::item_t item_in,
	output sdf_pkg::item_t     item_out
);

	logic signed [sdf_pkg::VALUE_W-1:0] entry_q;
	logic                               used_q;
	sdf_pkg::item_t                     item_q;
	sdf_pkg::item_t                     item_nxt;
	logic                               match;
	logic                               take;

	always_comb begin
		match    = used_q && (entry_q == item_in.value);
		// first free cell reached by a word not found upstream claims it
		take     = item_in.vld && !item_in.hit && !item_in.placed && !used_q;
		item_nxt = item_in;
		if (item_in.vld) begin
			item_nxt.hit    = item_in.hit | match;
			item_nxt.placed = item_in.placed | take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_nxt;
			// drop the entry behind the last word of an array
			if (item_in.vld && item_in.last) begin
				used_q <= 1'b0;
			end else if (take) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			entry_q <= item_in.value;
		end
	end

	assign item_out = item_q;

endmodule

`default_nettype wire

FILE: rtl/sdf_out.sv
// Output stage: running distinct count and the result register.
`default_nettype none

module sdf_out #(
	parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire sdf_pkg::item_t tail,
	output logic                res_vld,
	output sdf_pkg::out_word_t  res
);

	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cnt_nxt;
	logic [31:0]            cnt_wide;
	logic                   res_vld_q;
	sdf_pkg::out_word_t     res_q;

	always_comb begin
		cnt_nxt  = tail.placed ? (count_q + CW'(1)) : count_q;
		cnt_wide = 32'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= tail.vld;
			if (tail.vld) begin
				count_q <= tail.last ? '0 : cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.vld) begin
			res_q.out_value    <= tail.value;
			res_q.keep         <= !tail.hit;
			res_q.unique_count <= cnt_wide[sdf_pkg::COUNT_FIELD_W-1:0];
			res_q.end_of_array <= tail.last;
			res_q.overflow     <= !tail.hit && !tail.placed;
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

`default_nettype wire

FILE: rtl/stream_duplicate_filter_unit.sv
// Top level of the stream duplicate filter: cell chain plus output stage.
//
//  channel | valid        | stall        | word
//  --------+--------------+--------------+-----------------------------
//  input   | item_valid   | item_stall   | item   (value, last)
//  result  | result_valid | result_stall | result (value, keep, count, eoa, ovf)
//
// One word enters per cycle while the result side keeps up; each word walks
// the chain of STORE_DEPTH cells, one cell per cycle while nothing stalls,
// and then the result register. Reset empties every cell and the
// pipeline at once. A stalled result freezes the whole chain; the input is
// stalled only while the result register holds a word that is not taken.
`default_nettype none

module stream_duplicate_filter_unit #(
	parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire sdf_pkg::in_word_t item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output sdf_pkg::out_word_t     result
);

	localparam int FULL_W = 32;
	localparam logic [FULL_W-1:0] FULL_CNT = FULL_W'(STORE_DEPTH);

	sdf_pkg::item_t chain [STORE_DEPTH+1];
	logic           adv;

	// advance whenever the result register is free or being emptied
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	always_comb begin
		chain[0].vld    = item_valid;
		chain[0].value  = item.value;
		chain[0].last   = item.last;
		chain[0].hit    = 1'b0;
		chain[0].placed = 1'b0;
	end

	for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
		sdf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.item_in  (chain[k]),
			.item_out (chain[k+1])
		);
	end

	sdf_out #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tail    (chain[STORE_DEPTH]),
		.res_vld (result_valid),
		.res     (result)
	);

	a_ovf_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.keep)
		else $error("overflow result without keep");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |->
		result.unique_count == FULL_CNT[sdf_pkg::COUNT_FIELD_W-1:0])
		else $error("overflow reported below full count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a blocked result");

	a_eoa_restart: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.end_of_array |=>
		!(result_valid && result.overflow) || result.keep)
		else $error("result after end of array inconsistent");

endmodule

`default_nettype wire

FILE: sim/stream_duplicate_filter_checker.sv
// Watches both channels of the duplicate filter, predicts each result word and compares.
`timescale 1ns / 100ps

module stream_duplicate_filter_checker #(
	parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  sdf_pkg::in_word_t  item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  sdf_pkg::out_word_t result,
	output int                 mismatches,
	output int                 pending
);

	logic signed [sdf_pkg::VALUE_W-1:0] distinct_vals [STORE_DEPTH];
	int                                 distinct_cnt = 0;
	sdf_pkg::out_word_t                 pending_results [$];
	int                                 mismatch_cnt = 0;

	// Look the value up among the distinct values of the current array and store it if new
	function automatic sdf_pkg::out_word_t dedup_step(input sdf_pkg::in_word_t w);
		sdf_pkg::out_word_t r;
		logic               found;
		found = 1'b0;
		for (int i = 0; i < distinct_cnt; i++)
			if (distinct_vals[i] == w.value)
				found = 1'b1;
		r.out_value = w.value;
		r.keep = !found;
		r.overflow = 1'b0;
		if (!found) begin
			if (distinct_cnt < STORE_DEPTH) begin
				distinct_vals[distinct_cnt] = w.value;
				distinct_cnt++;
			end else begin
				r.overflow = 1'b1;
			end
		end
		r.unique_count = sdf_pkg::COUNT_FIELD_W'(distinct_cnt);
		r.end_of_array = w.last;
		// the last word closes the array: empty the store
		if (w.last)
			distinct_cnt = 0;
		return r;
	endfunction

	task automatic compare_word(input sdf_pkg::out_word_t exp_w, input sdf_pkg::out_word_t got);
		if (exp_w.out_value !== got.out_value || exp_w.keep !== got.keep
				|| exp_w.unique_count !== got.unique_count
				|| exp_w.end_of_array !== got.end_of_array
				|| exp_w.overflow !== got.overflow) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10) begin
				$write("mismatch: expected value %0d keep %0b count %0d eoa %0b ovf %0b,",
					exp_w.out_value, exp_w.keep, exp_w.unique_count,
					exp_w.end_of_array, exp_w.overflow);
				$display(" got value %0d keep %0b count %0d eoa %0b ovf %0b",
					got.out_value, got.keep, got.unique_count,
					got.end_of_array, got.overflow);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: result word value %0d with nothing expected",
							result.out_value);
				end else begin
					compare_word(pending_results.pop_front(), result);
				end
			end
			if (item_valid && !item_stall)
				pending_results.push_back(dedup_step(item));
		end
		mismatches <= mismatch_cnt;
		pending <= pending_results.size();
	end

endmodule

FILE: sim/stream_duplicate_filter_unit_test.sv
// Stimulus and verdict for the stream duplicate filter, with the checker beside the block.
`timescale 1ns / 100ps

module stream_duplicate_filter_unit_test;

	localparam int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEF;
	localparam int ITEM_TARGET = 1250;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	sdf_pkg::in_word_t  item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	sdf_pkg::out_word_t result;
	int                 mismatches;
	int                 pending;
	bit                 calm = 1'b0;
	int                 sent = 0;

	always #5 clk = ~clk;

	stream_duplicate_filter_unit #(.STORE_DEPTH(STORE_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	stream_duplicate_filter_checker #(.STORE_DEPTH(STORE_DEPTH)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always @(posedge clk)
		result_stall <= !calm && ($urandom_range(99) < 22);

	task automatic send_word(input logic signed [sdf_pkg::VALUE_W-1:0] v,
			input logic is_last);
		sdf_pkg::in_word_t w;
		w.value = v;
		w.last = is_last;
		// idle with junk on the bus
		while (!calm && $urandom_range(99) < 22) begin
			item_valid <= 1'b0;
			item <= {$urandom, 1'($urandom)};
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (item_stall);
		sent++;
	endtask

	// hold the input idle until every expected result is back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [sdf_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed(32'($urandom_range(0, 7))) - 32'sd4;
			default: return $urandom;
		endcase
	endfunction

	// Wide arrays mostly bring fresh values so the store fills; narrow ones repeat often
	task automatic send_array(input int len, input bit wide);
		logic signed [sdf_pkg::VALUE_W-1:0] history [$];
		logic signed [sdf_pkg::VALUE_W-1:0] v;
		for (int i = 0; i < len; i++) begin
			if (history.size() != 0 && $urandom_range(99) < (wide ? 20 : 35))
				v = history[$urandom_range(0, history.size() - 1)];
			else
				v = wide ? $signed($urandom) : pick_value();
			history.push_back(v);
			send_word(v, i == len - 1);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes and small values in one array; the negative extreme and -1 repeat
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sd1, 1'b1);
		// one-word array
		send_word(32'sh1234_5678, 1'b1);
		// array closed by a repeat; the next array must start empty
		send_word(32'sd5, 1'b0);
		send_word(32'sd5, 1'b1);
		send_word(32'sd5, 1'b1);
		send_word(32'sd0, 1'b0);
		send_word(32'sd0, 1'b1);
		// hold off until every result is back
		drain();

		// start with a store overflow
		send_array(100, 1'b1);
		while (sent < ITEM_TARGET) begin
			calm <= (sent >= 400 && sent < 650);
			if ($urandom_range(99) < 12)
				send_array($urandom_range(70, 110), 1'b1);
			else
				send_array($urandom_range(1, 24), 1'b0);
			if ($urandom_range(99) < 6)
				drain();
		end

		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("stream_duplicate_filter_unit_test passed");
		else
			$display("stream_duplicate_filter_unit_test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("stream_duplicate_filter_unit_test failed");
		$finish;
	end

endmodule
